/* hw/rtl/tilt_complementary_filter_core_defines.svh */
// ----------------------------------------------------------------------------
// tilt filter assertion macros
// shared property wrappers for the tilt filter core
// ----------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_CORE_DEFINES_SVH

// implication checked on every edge outside reset
`define TCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcf assertion failed");

// implication checked in the cycle after the antecedent
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcf assertion failed");

`endif

/* hw/rtl/tcf_pkg.sv */
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types, constants and angle table for the tilt filter
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int NUM_CELLS    = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CNT_W        = $clog2(NUM_CELLS + 1);
    localparam int SH_W         = 5;
    localparam int XY_W         = 52;
    localparam int Z_W          = 32;
    localparam int SQ_W         = 33;
    localparam int RT_W         = 33;
    localparam logic [15:0] WEIGHT_RESET = 16'd64225;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CORDIC,
        ST_GYRO,
        ST_BLEND,
        ST_OUT
    } t_state;

    // one cordic lane handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_lane;

    function automatic logic signed [Z_W-1:0] atan_q8(input logic [SH_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 32'sd11520000;
            5'd1:  v = 32'sd6800653;
            5'd2:  v = 32'sd3593278;
            5'd3:  v = 32'sd1824004;
            5'd4:  v = 32'sd915542;
            5'd5:  v = 32'sd458217;
            5'd6:  v = 32'sd229164;
            5'd7:  v = 32'sd114589;
            5'd8:  v = 32'sd57295;
            5'd9:  v = 32'sd28648;
            5'd10: v = 32'sd14324;
            5'd11: v = 32'sd7162;
            5'd12: v = 32'sd3581;
            5'd13: v = 32'sd1790;
            5'd14: v = 32'sd895;
            5'd15: v = 32'sd448;
            5'd16: v = 32'sd224;
            5'd17: v = 32'sd112;
            5'd18: v = 32'sd56;
            5'd19: v = 32'sd28;
            5'd20: v = 32'sd14;
            5'd21: v = 32'sd7;
            5'd22: v = 32'sd3;
            5'd23: v = 32'sd2;
            5'd24: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/tcf_sqrt.sv */
// ----------------------------------------------------------------------------
// tcf_sqrt
// bit-serial integer square root of s * 2^32, one result bit per cycle
// ----------------------------------------------------------------------------
module tcf_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tcf_pkg::SQ_W-1:0]      i_sq,
    output logic                          o_done,
    output logic [tcf_pkg::RT_W-1:0]      o_root
);
    // radicand padded to an even width so the bit pairs line up with bit 0
    localparam int RAD_W = tcf_pkg::SQ_W + 33;
    localparam int CW    = $clog2(tcf_pkg::RT_W + 1);

    logic [RAD_W-1:0]       r_rad, n_rad;
    logic [tcf_pkg::RT_W+1:0] r_rem, n_rem;
    logic [tcf_pkg::RT_W-1:0] r_root, n_root;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic [tcf_pkg::RT_W+1:0] w_trial;
    logic [tcf_pkg::RT_W+1:0] w_shrem;

    always_comb begin
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_shrem = {r_rem[tcf_pkg::RT_W-1:0], r_rad[RAD_W-1 -: 2]};
        w_trial = {r_root, 2'b01};
        if (i_start) begin
            n_rad  = {1'b0, i_sq, 32'd0};
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CW'(tcf_pkg::RT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[RAD_W-3:0], 2'b00};
            if (w_shrem >= w_trial) begin
                n_rem  = w_shrem - w_trial;
                n_root = {r_root[tcf_pkg::RT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_shrem;
                n_root = {r_root[tcf_pkg::RT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_root = n_root;
endmodule

/* hw/rtl/tcf_cell.sv */
// ----------------------------------------------------------------------------
// tcf_cell
// one cordic vectoring step with a fixed shift, registered toward its neighbor
// ----------------------------------------------------------------------------
module tcf_cell (
    input  logic                     i_clk,
    input  logic [tcf_pkg::SH_W-1:0] i_idx,
    input  logic                     i_load,
    input  tcf_pkg::t_lane           i_lane,
    output tcf_pkg::t_lane           o_lane
);
    tcf_pkg::t_lane r_lane, n_lane;
    logic signed [tcf_pkg::XY_W-1:0] w_dx, w_dy;

    always_comb begin
        w_dx = i_lane.y >>> i_idx;
        w_dy = i_lane.x >>> i_idx;
        n_lane = i_lane;
        if (!i_lane.y[tcf_pkg::XY_W-1]) begin
            n_lane.x = i_lane.x + w_dx;
            n_lane.y = i_lane.y - w_dy;
            n_lane.z = i_lane.z + tcf_pkg::atan_q8(i_idx);
        end else begin
            n_lane.x = i_lane.x - w_dx;
            n_lane.y = i_lane.y + w_dy;
            n_lane.z = i_lane.z - tcf_pkg::atan_q8(i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

/* hw/rtl/tilt_complementary_filter_core.sv */
// ----------------------------------------------------------------------------
// tilt_complementary_filter_core
// accelerometer pitch/roll by cordic and complementary fusion of the pitch
// ----------------------------------------------------------------------------
// channel   | dir | handshake                  | payload
// s_axis    | in  | s_axis_tvalid/tready       | ax, ay, az, gyro rate, elapsed ms
// m_axis    | out | m_axis_tvalid/tready       | accel pitch, accel roll, fused pitch
// cfg       | in  | i_cfg_valid/o_cfg_ready    | blend weight
//
// one sample is taken at a time (s_axis_tready is high only in idle); per sample
// each pass (pitch, then roll) runs the root (setup, then the 33-bit root bit by bit)
// and the cell row; then the gyro divide, the blend, the output and back to idle
// reset (synchronous, active low) clears the estimate and loads weight 0.98
// a held result does not block the next sample; only a full output stalls
// ----------------------------------------------------------------------------
module tilt_complementary_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // ax[15:0], ay[31:16], az[47:32], gyro_rate_x[67:48], elapsed_ms[83:68], pad
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accel_pitch[17:0], accel_roll[35:18], fused_pitch[59:36], pad
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
`include "tilt_complementary_filter_core_defines.svh"

    localparam int N  = tcf_pkg::NUM_CELLS;
    localparam int CW = tcf_pkg::CNT_W;
    localparam logic signed [tcf_pkg::Z_W-1:0] ZLIM = 32'sd23040000;
    // ceil(2^38 / 1000), exact floor division for any 32-bit dividend
    localparam logic [28:0] RECIP_1000 = 29'd274877907;

    tcf_pkg::t_state r_state, n_state;

    // input beat capture
    logic signed [15:0] r_ax, r_ay, r_az;
    logic signed [19:0] r_rate;
    logic [15:0]        r_ms;
    logic [15:0]        r_w;
    logic signed [31:0] r_est;
    logic               r_pass;        // 0 pitch, 1 roll
    logic [CW-1:0]      r_cnt;
    logic [1:0]         r_sub;
    logic signed [31:0] r_pq8, r_rq8;
    logic signed [47:0] r_prod;
    logic signed [49:0] r_gq;
    logic signed [63:0] r_acc;
    logic               r_oval;
    logic [63:0]        r_odata;

    // squares for the current pass
    logic signed [15:0] w_a, w_b;
    logic signed [16:0] w_num;
    logic [tcf_pkg::SQ_W-1:0] r_sq;
    logic               w_sq_start, w_sq_done;
    logic [tcf_pkg::RT_W-1:0] w_root;
    logic [tcf_pkg::RT_W-1:0] r_root;

    logic               w_in_acc, w_out_acc;
    logic               w_load;
    tcf_pkg::t_lane     w_lane_in [N];
    tcf_pkg::t_lane     w_lane_out [N];
    tcf_pkg::t_lane     w_seed_lane;
    logic signed [tcf_pkg::Z_W-1:0] w_zc;
    logic               w_zero;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == tcf_pkg::ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    // numerator widened so that negating the most negative axis stays exact
    always_comb begin
        w_a   = r_pass ? r_ay : r_ax;
        w_b   = r_az;
        w_num = r_pass ? 17'(r_ax) : -17'(r_ay);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcf_pkg::ST_IDLE:   if (w_in_acc) n_state = tcf_pkg::ST_ROOT;
            tcf_pkg::ST_ROOT:   if (w_sq_done) n_state = tcf_pkg::ST_CORDIC;
            tcf_pkg::ST_CORDIC: begin
                if (r_cnt == CW'(N)) begin
                    n_state = r_pass ? tcf_pkg::ST_GYRO : tcf_pkg::ST_ROOT;
                end
            end
            tcf_pkg::ST_GYRO:   if (r_sub == 2'd3) n_state = tcf_pkg::ST_BLEND;
            tcf_pkg::ST_BLEND:  if (r_sub == 2'd1) n_state = tcf_pkg::ST_OUT;
            tcf_pkg::ST_OUT:    if (!r_oval || m_axis_tready) n_state = tcf_pkg::ST_IDLE;
            default:            n_state = tcf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_sq_start = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            tcf_pkg::ST_ROOT:   w_sq_start = (r_sub == 2'd1);
            tcf_pkg::ST_CORDIC: w_load = 1'b1;
            default: ;
        endcase
    end

    tcf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_sq    (r_sq),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // chain of cells: each cell feeds its neighbor; cell 0 takes the seed
    assign w_seed_lane.x = tcf_pkg::XY_W'($signed({1'b0, r_root}));
    assign w_seed_lane.y = tcf_pkg::XY_W'($signed({w_num, 16'd0}));
    assign w_seed_lane.z = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_lane_in[g] = w_seed_lane;
            end else begin : g_next
                assign w_lane_in[g] = w_lane_out[g-1];
            end
            tcf_cell u_cell (
                .i_clk  (i_clk),
                .i_idx  (tcf_pkg::SH_W'(g)),
                .i_load (w_load),
                .i_lane (w_lane_in[g]),
                .o_lane (w_lane_out[g])
            );
        end
    endgenerate

    // zero vector and clamp of the last cell's angle
    always_comb begin
        w_zero = (r_root == '0) && (w_num == '0);
        w_zc   = w_lane_out[N-1].z;
        if (w_zc > ZLIM) w_zc = ZLIM;
        if (w_zc < -ZLIM) w_zc = -ZLIM;
        if (w_zero) w_zc = '0;
    end

    logic [49:0]        w_mag;
    logic signed [63:0] w_rnd;
    logic signed [31:0] w_np;
    logic signed [17:0] w_pm, w_rm;
    logic signed [31:0] w_pround, w_rround;

    always_comb begin
        w_mag  = r_prod[47] ? 50'(-r_prod) : 50'(r_prod);
        w_rnd  = r_acc + 64'sd32768;
        w_np   = 32'(w_rnd >>> 16);
        if ((w_rnd >>> 16) > 64'sd2147483647) w_np = 32'h7fffffff;
        if ((w_rnd >>> 16) < -64'sd2147483648) w_np = 32'h80000000;
        w_pround = (r_pq8 + 32'sd128) >>> 8;
        w_rround = (r_rq8 + 32'sd128) >>> 8;
        w_pm = w_pround[17:0];
        w_rm = w_rround[17:0];
    end

    // gyro divide by 1000 in two 22-bit digits by reciprocal multiplication:
    // high quotient, its remainder joined to the low bits, then low quotient
    logic [43:0] r_dnum;
    logic [12:0] r_q1;
    logic [31:0] r_dn2;
    logic [50:0] w_p1;
    logic [21:0] w_r1full;
    logic [9:0]  w_r1;
    logic [60:0] w_p2;
    logic [34:0] w_q;

    always_comb begin
        w_p1     = 51'(r_dnum[43:22]) * 51'(RECIP_1000);
        w_r1full = r_dnum[43:22] - 22'(r_q1) * 22'd1000;
        w_r1     = w_r1full[9:0];
        w_p2     = 61'(r_dn2) * 61'(RECIP_1000);
        w_q      = {r_q1, w_p2[59:38]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcf_pkg::ST_IDLE;
            r_w     <= tcf_pkg::WEIGHT_RESET;
            r_est   <= '0;
            r_oval  <= 1'b0;
            r_cnt   <= '0;
            r_sub   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_w <= i_cfg_data;
            if (r_state == tcf_pkg::ST_OUT && (!r_oval || m_axis_tready)) begin
                r_oval <= 1'b1;
            end else if (w_out_acc) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                tcf_pkg::ST_IDLE: begin
                    r_sub  <= '0;
                    r_cnt  <= '0;
                    r_pass <= 1'b0;
                end
                tcf_pkg::ST_ROOT: begin
                    if (w_sq_done) begin
                        r_sub <= '0;
                        r_cnt <= '0;
                    end else if (r_sub != 2'd2) begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
                tcf_pkg::ST_CORDIC: begin
                    if (r_cnt == CW'(N)) begin
                        r_cnt  <= '0;
                        r_pass <= 1'b1;
                        r_sub  <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                tcf_pkg::ST_GYRO:  r_sub <= r_sub + 2'd1;
                tcf_pkg::ST_BLEND: r_sub <= r_sub + 2'd1;
                tcf_pkg::ST_OUT: begin
                    if (!r_oval || m_axis_tready) begin
                        r_est <= w_np;
                    end
                end
                default: ;
            endcase
        end
    end

    function automatic logic [tcf_pkg::SQ_W-1:0] SQ_EXT(input logic signed [15:0] v);
        logic signed [31:0] p;
        p = v * v;
        return tcf_pkg::SQ_W'($unsigned(p));
    endfunction

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ax   <= s_axis_tdata[15:0];
            r_ay   <= s_axis_tdata[31:16];
            r_az   <= s_axis_tdata[47:32];
            r_rate <= s_axis_tdata[67:48];
            r_ms   <= s_axis_tdata[83:68];
        end
        r_sq <= SQ_EXT(w_a) + SQ_EXT(w_b);
        if (w_sq_done) r_root <= w_root;
        if (r_state == tcf_pkg::ST_CORDIC && r_cnt == CW'(N)) begin
            if (r_pass) r_rq8 <= w_zc;
            else        r_pq8 <= w_zc;
        end
        case (r_state)
            tcf_pkg::ST_GYRO: begin
                case (r_sub)
                    2'd0: r_dnum <= w_mag[43:0] + 44'd500;
                    2'd1: r_q1   <= w_p1[50:38];
                    2'd2: r_dn2  <= {w_r1, r_dnum[21:0]};
                    default: begin
                        r_gq <= r_prod[47] ? -50'($signed({1'b0, w_q}))
                                           : 50'($signed({1'b0, w_q}));
                    end
                endcase
            end
            tcf_pkg::ST_BLEND: begin
                if (r_sub == 2'd0) begin
                    r_acc <= $signed({1'b0, r_w}) * (64'(r_est) + 64'(r_gq))
                           + $signed(18'd65536 - {2'b0, r_w}) * 64'(r_pq8);
                end
            end
            tcf_pkg::ST_OUT: begin
                if (!r_oval || m_axis_tready) begin
                    r_odata <= {4'd0, w_np[31:8], w_rm, w_pm};
                end
            end
            default: ;
        endcase
        // rate*ms*256
        r_prod <= 48'($signed(r_rate) * $signed({1'b0, r_ms})) <<< 8;
    end

    // assertions
    `TCF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TCF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    `TCF_ASSERT_IMPL(a_load_cordic, i_clk, i_rst_n, w_load, r_state == tcf_pkg::ST_CORDIC)

endmodule
